/* hdl/greedy_line_breaker_assert.svh */
// Assertion macros for the greedy line breaker.
`ifndef GREEDY_LINE_BREAKER_ASSERT_SVH
`define GREEDY_LINE_BREAKER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define GLB_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, checked out of reset.
`define GLB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define GLB_ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define GLB_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

/* hdl/glb_pkg.sv */
// Shared types and constants for the greedy line breaker.
package glb_pkg;

    // Default parameter values
    localparam int OFFSET_BITS_DEF  = 16;
    localparam int ADVANCE_BITS_DEF = 17;

    // Field widths
    localparam int CP_W     = 21;
    localparam int GLYPH_W  = 12;
    localparam int OFFS_W   = 16;
    localparam int COUNT_W  = 8;
    localparam int WIDTH_W  = 16;
    localparam int LIMIT_W  = 8;

    // Stream widths, padded to whole bytes
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 24;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 21;

    localparam logic [WIDTH_W-1:0] LINE_WIDTH_RST  = 16'hFFFF;
    localparam logic [CP_W-1:0]    DELIMITER_RST   = 21'd32;
    localparam logic [LIMIT_W-1:0] BREAK_LIMIT_RST = 8'd0;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 8'hFF;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LINE_WIDTH  = 2'd0,
        REG_DELIMITER   = 2'd1,
        REG_BREAK_LIMIT = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic               start_of_text;
        logic [CP_W-1:0]    codepoint;
        logic [GLYPH_W-1:0] glyph_advance;
        logic [OFFS_W-1:0]  next_offset;
    } item_t;

    typedef struct packed {
        logic [OFFS_W-1:0]  break_offset;
        logic [COUNT_W-1:0] break_count;
        logic               limit_reached;
    } result_t;

    typedef struct packed {
        logic stopped;
        logic result_valid;
    } core_status_t;

endpackage

/* hdl/glb_in_reg.sv */
// Input register stage: holds one accepted word until the core takes it.
module glb_in_reg
    import glb_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  advance,
    output logic  hold_valid,
    output item_t hold_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Accept when empty or when the held word leaves this cycle
    assign in_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on accept
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_item  = item_reg;

endmodule

/* hdl/glb_core.sv */
// Wrap core: configuration registers, running line state and break decision.
module glb_core
    import glb_pkg::*;
#(
    parameter int OFFSET_BITS  = OFFSET_BITS_DEF,
    parameter int ADVANCE_BITS = ADVANCE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  fire,
    input  item_t                 item,
    output result_t               result,
    output core_status_t          status
);

    localparam int CMP_W = (ADVANCE_BITS > WIDTH_W) ? ADVANCE_BITS : WIDTH_W;

    // Configuration
    logic [WIDTH_W-1:0] line_width_reg;
    logic [CP_W-1:0]    delimiter_reg;
    logic [LIMIT_W-1:0] break_limit_reg;

    // Running state
    logic [ADVANCE_BITS-1:0] line_adv_reg,  line_adv_next;
    logic [ADVANCE_BITS-1:0] word_adv_reg,  word_adv_next;
    logic [OFFSET_BITS-1:0]  pend_reg,      pend_next;
    logic [COUNT_W-1:0]      count_reg,     count_next;
    logic                    stopped_reg,   stopped_next;

    // Working values
    logic [ADVANCE_BITS-1:0] cur_line, cur_word, word_mid, word_sat, grown;
    logic [OFFSET_BITS-1:0]  cur_pend, pend_mid, offs_trunc;
    logic [COUNT_W-1:0]      cur_count, count_inc;
    logic                    cur_stop, is_delim, over, brk, hit;
    logic [ADVANCE_BITS:0]   adv_ext, word_sum, line_sum;
    logic [31:0]             offs_wide, pend_wide;

    // Write configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg  <= LINE_WIDTH_RST;
            delimiter_reg   <= DELIMITER_RST;
            break_limit_reg <= BREAK_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_addr))
                REG_LINE_WIDTH:  line_width_reg  <= cfg_wdata[WIDTH_W-1:0];
                REG_DELIMITER:   delimiter_reg   <= cfg_wdata[CP_W-1:0];
                REG_BREAK_LIMIT: break_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clear running state at start of text
    always_comb begin
        cur_line  = item.start_of_text ? '0 : line_adv_reg;
        cur_word  = item.start_of_text ? '0 : word_adv_reg;
        cur_pend  = item.start_of_text ? '0 : pend_reg;
        cur_count = item.start_of_text ? '0 : count_reg;
        cur_stop  = item.start_of_text ? 1'b0 : stopped_reg;
    end

    // Word tracking and saturating advances
    always_comb begin
        is_delim   = (delimiter_reg == '0) || (item.codepoint == delimiter_reg);
        offs_wide  = 32'(item.next_offset);
        offs_trunc = offs_wide[OFFSET_BITS-1:0];
        adv_ext    = (ADVANCE_BITS+1)'(item.glyph_advance);
        word_sum   = {1'b0, cur_word} + adv_ext;
        word_sat   = word_sum[ADVANCE_BITS] ? '1 : word_sum[ADVANCE_BITS-1:0];
        line_sum   = {1'b0, cur_line} + adv_ext;
        grown      = line_sum[ADVANCE_BITS] ? '1 : line_sum[ADVANCE_BITS-1:0];
        word_mid   = is_delim ? '0 : word_sat;
        pend_mid   = is_delim ? offs_trunc : cur_pend;
    end

    // Break decision
    always_comb begin
        over      = CMP_W'(grown) > CMP_W'(line_width_reg);
        brk       = !cur_stop && (pend_mid != '0) && over;
        count_inc = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;
        hit       = (break_limit_reg != '0) && (count_inc == break_limit_reg);
    end

    // Next running state
    always_comb begin
        line_adv_next = cur_line;
        word_adv_next = cur_word;
        pend_next     = cur_pend;
        count_next    = cur_count;
        stopped_next  = cur_stop;
        if (!cur_stop) begin
            word_adv_next = word_mid;
            pend_next     = pend_mid;
            if (brk) begin
                count_next = count_inc;
                if (hit) begin
                    stopped_next = 1'b1;
                end else begin
                    line_adv_next = word_mid;
                    word_adv_next = '0;
                    pend_next     = '0;
                end
            end else begin
                line_adv_next = grown;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_adv_reg <= '0;
            word_adv_reg <= '0;
            pend_reg     <= '0;
            count_reg    <= '0;
            stopped_reg  <= 1'b0;
        end else if (fire) begin
            line_adv_reg <= line_adv_next;
            word_adv_reg <= word_adv_next;
            pend_reg     <= pend_next;
            count_reg    <= count_next;
            stopped_reg  <= stopped_next;
        end
    end

    // Result word
    assign pend_wide            = 32'(pend_mid);
    assign result.break_offset  = pend_wide[OFFS_W-1:0];
    assign result.break_count   = count_inc;
    assign result.limit_reached = hit;

    assign status.stopped      = stopped_reg;
    assign status.result_valid = brk;

endmodule

/* hdl/glb_out_reg.sv */
// Result register: holds one break word until the sink takes it.
module glb_out_reg
    import glb_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t load_result,
    output logic    free,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // Room for a new word when empty or when the held one is taken now
    assign free = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

/* hdl/greedy_line_breaker.sv */
// Greedy line breaker top level: streams, configuration port and checks.
// One character word is accepted per cycle while the input is not stalled. A word
// passes an input register, is evaluated combinationally against the running
// line state in the core, and a break, if any, lands in the result register.
// The running state updates once per character, so throughput is one character
// per clock when the input does not stall. The input stalls only while a character
// waits in the input register and the result register still holds a break word
// that the sink has not taken.
`include "greedy_line_breaker_assert.svh"

module greedy_line_breaker
    import glb_pkg::*;
#(
    parameter int OFFSET_BITS  = OFFSET_BITS_DEF,
    parameter int ADVANCE_BITS = ADVANCE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Character stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [20:0] codepoint, [32:21] glyph_advance, [48:33] next_offset, [55:49] zero
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // [0] start_of_text
    input  logic                  s_axis_tuser,
    // Break stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [15:0] break_offset, [23:16] break_count
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // limit_reached
    output logic                  m_axis_tlast
);

    item_t        in_item, hold_item;
    logic         hold_valid, fire, out_free;
    result_t      core_result, out_result;
    core_status_t core_status;

    // Unpack the input word
    always_comb begin
        in_item.start_of_text = s_axis_tuser;
        in_item.codepoint     = s_axis_tdata[CP_W-1:0];
        in_item.glyph_advance = s_axis_tdata[CP_W+GLYPH_W-1:CP_W];
        in_item.next_offset   = s_axis_tdata[CP_W+GLYPH_W+OFFS_W-1:CP_W+GLYPH_W];
    end

    // Advance the held character when the result side has room
    assign fire = hold_valid && out_free;

    glb_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (fire),
        .hold_valid (hold_valid),
        .hold_item  (hold_item)
    );

    glb_core #(
        .OFFSET_BITS  (OFFSET_BITS),
        .ADVANCE_BITS (ADVANCE_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .item      (hold_item),
        .result    (core_result),
        .status    (core_status)
    );

    glb_out_reg u_out_reg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (fire && core_status.result_valid),
        .load_result (core_result),
        .free        (out_free),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_result  (out_result)
    );

    // Pack the break word
    assign m_axis_tdata = {out_result.break_count, out_result.break_offset};
    assign m_axis_tlast = out_result.limit_reached;

    // A break that reaches the limit leaves the core stopped
    `GLB_ASSERT_IMPLIES(a_limit_stops, aclk, aresetn, m_axis_tvalid && m_axis_tlast, core_status.stopped)
    // A break always carries a nonzero count
    `GLB_ASSERT_IMPLIES(a_count_nonzero, aclk, aresetn, m_axis_tvalid, m_axis_tdata[23:16] != 8'd0)
    // Input back-pressure only while a character is held
    `GLB_ASSERT_IMPLIES(a_ready_held, aclk, aresetn, !s_axis_tready, hold_valid)
    // A stalled character stays in the input register
    `GLB_ASSERT_NEXT(a_hold_keeps, aclk, aresetn, hold_valid && !fire, hold_valid)

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the greedy line breaker: stream stimulus, break prediction, checks.
module testbench
    import glb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADV_BITS = ADVANCE_BITS_DEF;
    localparam logic [ADV_BITS-1:0] ADV_MAX = '1;
    localparam int MAX_CODEPOINT = 1114111;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;

    // Predict break words from accepted characters and check them in order
    class break_scoreboard;
        logic [WIDTH_W-1:0]  line_width;
        logic [CP_W-1:0]     delimiter;
        logic [LIMIT_W-1:0]  break_limit;
        logic [ADV_BITS-1:0] line_adv;
        logic [ADV_BITS-1:0] word_adv;
        logic [OFFS_W-1:0]   pending_pos;
        logic [COUNT_W-1:0]  breaks_done;
        logic                stopped;
        result_t             expected_breaks[$];
        int                  errors;

        function new();
            line_width  = LINE_WIDTH_RST;
            delimiter   = DELIMITER_RST;
            break_limit = BREAK_LIMIT_RST;
            errors      = 0;
            clear_text();
        endfunction

        function void clear_text();
            line_adv    = '0;
            word_adv    = '0;
            pending_pos = '0;
            breaks_done = '0;
            stopped     = 1'b0;
        endfunction

        function logic [ADV_BITS-1:0] sat_add(logic [ADV_BITS-1:0] a, logic [GLYPH_W-1:0] b);
            logic [ADV_BITS:0] sum;
            sum = a + b;
            return (sum > ADV_MAX) ? ADV_MAX : sum[ADV_BITS-1:0];
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_LINE_WIDTH:  line_width  = value[WIDTH_W-1:0];
                REG_DELIMITER:   delimiter   = value[CP_W-1:0];
                REG_BREAK_LIMIT: break_limit = value[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the line state by one character; queue a break word if one falls out
        function void note_char(item_t ch);
            logic [ADV_BITS-1:0] grown;
            result_t brk;
            if (ch.start_of_text) clear_text();
            if (stopped) return;
            if (delimiter == '0 || ch.codepoint == delimiter) begin
                pending_pos = ch.next_offset;
                word_adv    = '0;
            end else begin
                word_adv = sat_add(word_adv, ch.glyph_advance);
            end
            grown = sat_add(line_adv, ch.glyph_advance);
            if (pending_pos != '0 && grown > line_width) begin
                if (breaks_done != COUNT_MAX) breaks_done++;
                brk.break_offset  = pending_pos;
                brk.break_count   = breaks_done;
                brk.limit_reached = (break_limit != '0 && breaks_done == break_limit);
                expected_breaks.push_back(brk);
                // Hold the state once the limit is hit, else start the new line
                if (brk.limit_reached) begin
                    stopped = 1'b1;
                end else begin
                    line_adv    = word_adv;
                    word_adv    = '0;
                    pending_pos = '0;
                end
            end else begin
                line_adv = grown;
            end
        endfunction

        function void check_break(logic [M_TDATA_W-1:0] word, logic last);
            result_t want;
            if (expected_breaks.size() == 0) begin
                errors++;
                $display("%0t: unexpected break word: offset %0d count %0d limit %0d",
                         $time, word[OFFS_W-1:0], word[OFFS_W+COUNT_W-1:OFFS_W], last);
                return;
            end
            want = expected_breaks.pop_front();
            if (word[OFFS_W-1:0] !== want.break_offset) begin
                errors++;
                $display("%0t: break_offset expected %0d actual %0d",
                         $time, want.break_offset, word[OFFS_W-1:0]);
            end
            if (word[OFFS_W+COUNT_W-1:OFFS_W] !== want.break_count) begin
                errors++;
                $display("%0t: break_count expected %0d actual %0d",
                         $time, want.break_count, word[OFFS_W+COUNT_W-1:OFFS_W]);
            end
            if (last !== want.limit_reached) begin
                errors++;
                $display("%0t: limit_reached expected %0d actual %0d",
                         $time, want.limit_reached, last);
            end
        endfunction

        function int outstanding();
            return expected_breaks.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tlast;

    break_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int sot_pct;
    int text_pos;
    int idle_cycles;

    greedy_line_breaker dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Take break words and toggle backpressure
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready)
                sb.check_break(m_axis_tdata, m_axis_tlast);
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // End the run if neither side moves a word for too long
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired with %0d breaks outstanding",
                         $time, sb.outstanding());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic logic [CP_W-1:0] plain_cp();
        logic [CP_W-1:0] cp;
        cp = $urandom_range(1) ? CP_W'($urandom_range(33, 126))
                               : CP_W'($urandom_range(0, MAX_CODEPOINT));
        if (sb.delimiter != '0 && cp == sb.delimiter) cp = sb.delimiter - 1'b1;
        return cp;
    endfunction

    function automatic logic [CP_W-1:0] delim_cp();
        if (sb.delimiter == '0) return CP_W'($urandom_range(0, MAX_CODEPOINT));
        return sb.delimiter;
    endfunction

    function automatic logic [GLYPH_W-1:0] glyph_adv();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5) return '0;
        if (pick < 10) return '1;
        return GLYPH_W'($urandom_range(1, 40));
    endfunction

    function automatic logic [OFFS_W-1:0] step_offset();
        text_pos += $urandom_range(1, 4);
        if (text_pos > 65535) text_pos = $urandom_range(1, 4);
        return OFFS_W'(text_pos);
    endfunction

    function automatic bit roll_sot();
        return $urandom_range(99) < sot_pct;
    endfunction

    // Present one character word, with a random gap ahead, and wait for its accept
    task automatic send_char(bit sot, logic [CP_W-1:0] cp, logic [GLYPH_W-1:0] adv,
                             logic [OFFS_W-1:0] offs);
        item_t ch;
        ch.start_of_text = sot;
        ch.codepoint     = cp;
        ch.glyph_advance = adv;
        ch.next_offset   = offs;
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W-CP_W-GLYPH_W-OFFS_W){1'b0}}, offs, adv, cp};
        s_axis_tuser  <= sot;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_char(ch);
    endtask

    // Hold the input until every expected break has come, then let the pipe empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.set_reg(idx, value);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(int width, int delim, int limit, int send_pct, int recv_pct,
                             int sot_chance);
        settle();
        write_reg(REG_LINE_WIDTH, CFG_DATA_W'(width));
        write_reg(REG_DELIMITER, CFG_DATA_W'(delim));
        write_reg(REG_BREAK_LIMIT, CFG_DATA_W'(limit));
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sot_pct        = sot_chance;
    endtask

    // Mostly words closed by a delimiter, some very wide words, some raw noise
    task automatic random_text(int n_chars);
        int sent;
        int kind;
        int len;
        sent = 0;
        while (sent < n_chars) begin
            kind = $urandom_range(99);
            if (kind < 72) begin
                len = $urandom_range(1, 9);
                for (int i = 0; i < len; i++)
                    send_char(i == 0 && roll_sot(), plain_cp(), glyph_adv(), step_offset());
                send_char(1'b0, delim_cp(), glyph_adv(), step_offset());
                sent += len + 1;
            end else if (kind < 77) begin
                // Wide word: drive both accumulators toward saturation
                len = $urandom_range(33, 36);
                for (int i = 0; i < len; i++)
                    send_char(i == 0 && sot_pct != 0 && $urandom_range(1), plain_cp(),
                              GLYPH_W'($urandom_range(3900, 4095)), step_offset());
                sent += len;
            end else begin
                send_char(roll_sot(), CP_W'($urandom_range(0, MAX_CODEPOINT)),
                          GLYPH_W'($urandom_range(0, 4095)),
                          ($urandom_range(99) == 0) ? '0 : OFFS_W'($urandom_range(1, 65535)));
                sent++;
            end
        end
    endtask

    initial begin
        sb = new();
        text_pos       = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sot_pct        = 0;
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_addr      <= REG_LINE_WIDTH;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Narrow line, limit of two: break, zero offset, stop, restart
        configure(20, 32, 2, 0, 0, 0);
        send_char(1'b1, 21'd97, 12'd8, 16'd1);
        send_char(1'b0, 21'd98, 12'd8, 16'd2);
        send_char(1'b0, 21'd32, 12'd4, 16'd3);
        send_char(1'b0, 21'd0, 12'd0, 16'd4);
        send_char(1'b0, 21'(MAX_CODEPOINT), 12'd4095, 16'd65535);
        send_char(1'b0, 21'd32, 12'd0, 16'd0);
        send_char(1'b0, 21'd120, 12'd1, 16'd7);
        send_char(1'b0, 21'd32, 12'd1, 16'd8);
        send_char(1'b0, 21'd121, 12'd5, 16'd9);
        send_char(1'b0, 21'd32, 12'd5, 16'd10);
        send_char(1'b1, 21'd122, 12'd4095, 16'd11);
        send_char(1'b0, 21'd32, 12'd4095, 16'd12);
        send_char(1'b0, 21'd33, 12'd2, 16'd13);

        // Zero width, every character a delimiter
        configure(0, 0, 0, 0, 0, 0);
        send_char(1'b1, 21'd0, 12'd0, 16'd1);
        send_char(1'b0, 21'(MAX_CODEPOINT), 12'd4095, 16'd65535);
        send_char(1'b0, 21'd32, 12'd1, 16'd0);
        send_char(1'b0, 21'd7, 12'd1, 16'd2);
        send_char(1'b0, 21'd32, 12'd0, 16'd3);
        send_char(1'b1, 21'd65, 12'd3, 16'd4);

        // Random text under several settings and idling patterns
        configure(160, 32, 0, 0, 0, 8);
        random_text(120);
        configure(0, 0, 0, 65, 0, 0);
        random_text(220);
        configure(65535, MAX_CODEPOINT, 255, 0, 65, 8);
        random_text(120);
        configure(300, 32, 3, 14, 14, 10);
        random_text(60);
        settle();
        random_text(60);
        configure($urandom_range(50, 1000), $urandom_range(1, 127), 1, 14, 14, 15);
        random_text(100);

        settle();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
